/* design/gbcr_pkg.sv */
// Package for the grid box cell registration block.
// Types, constants and controller state codes; no dependencies.
package gbcr_pkg;

    localparam int GRID_MAX_WIDTH    = 256;
    localparam int GRID_MAX_HEIGHT   = 256;
    localparam int RECORD_POOL_DEPTH = 4096;
    localparam int OWNER_SLOTS       = 256;

    localparam int CELL_COUNT = GRID_MAX_WIDTH * GRID_MAX_HEIGHT;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int OCC_WORDS  = (CELL_COUNT + 31) / 32;
    localparam int OCC_W      = $clog2(OCC_WORDS);
    localparam int REC_W      = $clog2(RECORD_POOL_DEPTH);
    localparam int USED_W     = $clog2(RECORD_POOL_DEPTH + 1);
    localparam int OWN_W      = $clog2(OWNER_SLOTS);
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 3;

    localparam logic [23:0] INDEX_NONE = 24'hFFFFFF;

    localparam logic [IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXTENT_X_LOW  = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXTENT_Y_LOW  = 3'd3;
    localparam logic [IDX_W-1:0] REG_EXTENT_X_HIGH = 3'd4;
    localparam logic [IDX_W-1:0] REG_EXTENT_Y_HIGH = 3'd5;

    typedef struct packed {
        logic signed [15:0] box_x_low;
        logic signed [15:0] box_y_low;
        logic signed [15:0] box_x_high;
        logic signed [15:0] box_y_high;
        logic [7:0]         owner_id;
        logic [7:0]         layer_flag;
    } box_item_t;

    typedef struct packed {
        logic [16:0] cells_added;
        logic        pool_full;
    } result_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CLAMP, ST_CLIP, ST_CHECK, ST_READ,
        ST_WAIT, ST_WRITE, ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture input item
        logic clamp;    // clamp box to extent
        logic clip;     // clip to grid, init walk
        logic clear;    // clear one head/occupancy/owner count entry
        logic read;     // issue memory reads for current cell
        logic write;    // commit the record
        logic full;     // mark pool exhausted
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_last;
        logic empty;      // clipped box has no cells
        logic pool_ok;    // a record can be taken
        logic walk_last;  // current cell is the last one
    } status_t;

endpackage

/* design/gbcr_if.sv */
// Valid/ready channel interfaces for the input boxes and the results.
// Depends on gbcr_pkg.
interface gbcr_box_if;
    logic                valid;
    logic                ready;
    gbcr_pkg::box_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbcr_result_if;
    logic                   valid;
    logic                   ready;
    gbcr_pkg::result_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/gbcr_ctrl.sv */
// Controller state machine of the grid box cell registration block.
// Depends on gbcr_pkg.
module gbcr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_load,
    input  logic              out_busy,
    input  gbcr_pkg::status_t status,
    output gbcr_pkg::cmd_t    cmd
);
    gbcr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbcr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbcr_pkg::ST_CLEAR: if (status.clear_last) state_next = gbcr_pkg::ST_IDLE;
            gbcr_pkg::ST_IDLE:  if (in_valid) state_next = gbcr_pkg::ST_CLAMP;
            gbcr_pkg::ST_CLAMP: state_next = gbcr_pkg::ST_CLIP;
            gbcr_pkg::ST_CLIP:  state_next = gbcr_pkg::ST_CHECK;
            gbcr_pkg::ST_CHECK:
            begin
                if (status.empty) state_next = gbcr_pkg::ST_DONE;
                else              state_next = gbcr_pkg::ST_READ;
            end
            gbcr_pkg::ST_READ:
            begin
                if (status.pool_ok) state_next = gbcr_pkg::ST_WAIT;
                else                state_next = gbcr_pkg::ST_DONE;
            end
            gbcr_pkg::ST_WAIT:  state_next = gbcr_pkg::ST_WRITE;
            gbcr_pkg::ST_WRITE:
            begin
                if (status.walk_last) state_next = gbcr_pkg::ST_DONE;
                else                  state_next = gbcr_pkg::ST_READ;
            end
            // Hold the result until the output register is free
            gbcr_pkg::ST_DONE:  if (!out_busy) state_next = gbcr_pkg::ST_IDLE;
            default:            state_next = gbcr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            gbcr_pkg::ST_CLEAR: cmd.clear = 1'b1;
            gbcr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            gbcr_pkg::ST_CLAMP: cmd.clamp = 1'b1;
            gbcr_pkg::ST_CLIP:  cmd.clip = 1'b1;
            gbcr_pkg::ST_READ:
            begin
                cmd.read = status.pool_ok;
                cmd.full = !status.pool_ok;
            end
            gbcr_pkg::ST_WRITE: cmd.write = 1'b1;
            gbcr_pkg::ST_DONE:  out_load = !out_busy;
            default:            cmd = '0;
        endcase
    end
endmodule

/* design/gbcr_datapath.sv */
// Datapath: config registers, clamp/clip, cell walk and the record memories.
// Depends on gbcr_pkg.
module gbcr_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [gbcr_pkg::IDX_W-1:0] cfg_index,
    input  logic [gbcr_pkg::CFG_W-1:0] cfg_data,
    input  gbcr_pkg::box_item_t      in_data,
    input  gbcr_pkg::cmd_t           cmd,
    output gbcr_pkg::status_t        status,
    output logic [16:0]              cells_added,
    output logic                     pool_full
);
    localparam int CW = gbcr_pkg::CELL_W;
    localparam int RW = gbcr_pkg::REC_W;
    localparam int UW = gbcr_pkg::USED_W;

    // Configuration
    logic [8:0]         grid_width_reg, grid_height_reg;
    logic signed [15:0] ext_xl_reg, ext_yl_reg, ext_xh_reg, ext_yh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
            ext_xl_reg      <= '0;
            ext_yl_reg      <= '0;
            ext_xh_reg      <= 16'sd256;
            ext_yh_reg      <= 16'sd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gbcr_pkg::REG_GRID_WIDTH:    grid_width_reg  <= cfg_data[8:0];
                gbcr_pkg::REG_GRID_HEIGHT:   grid_height_reg <= cfg_data[8:0];
                gbcr_pkg::REG_EXTENT_X_LOW:  ext_xl_reg      <= cfg_data;
                gbcr_pkg::REG_EXTENT_Y_LOW:  ext_yl_reg      <= cfg_data;
                gbcr_pkg::REG_EXTENT_X_HIGH: ext_xh_reg      <= cfg_data;
                gbcr_pkg::REG_EXTENT_Y_HIGH: ext_yh_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective grid size, clipped to the storage
    logic [12:0] w_eff, h_eff;
    assign w_eff = (13'(grid_width_reg) < 13'(gbcr_pkg::GRID_MAX_WIDTH))
                 ? 13'(grid_width_reg) : 13'(gbcr_pkg::GRID_MAX_WIDTH);
    assign h_eff = (13'(grid_height_reg) < 13'(gbcr_pkg::GRID_MAX_HEIGHT))
                 ? 13'(grid_height_reg) : 13'(gbcr_pkg::GRID_MAX_HEIGHT);

    // Item capture and box registers
    gbcr_pkg::box_item_t item_reg;
    logic signed [16:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic                nonempty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.clamp)
        begin
            x0_reg <= 17'(($signed(item_reg.box_x_low) > ext_xl_reg)
                          ? item_reg.box_x_low : ext_xl_reg);
            y0_reg <= 17'(($signed(item_reg.box_y_low) > ext_yl_reg)
                          ? item_reg.box_y_low : ext_yl_reg);
            x1_reg <= 17'(($signed(item_reg.box_x_high) < ext_xh_reg)
                          ? item_reg.box_x_high : ext_xh_reg);
            y1_reg <= 17'(($signed(item_reg.box_y_high) < ext_yh_reg)
                          ? item_reg.box_y_high : ext_yh_reg);
        end
    end

    // Clip against the grid: result in cell coordinates
    logic signed [16:0] cx0, cy0, cx1, cy1;
    assign cx0 = (x0_reg > 17'sd0) ? x0_reg : 17'sd0;
    assign cy0 = (y0_reg > 17'sd0) ? y0_reg : 17'sd0;
    assign cx1 = (x1_reg < $signed({4'd0, w_eff})) ? x1_reg : $signed({4'd0, w_eff});
    assign cy1 = (y1_reg < $signed({4'd0, h_eff})) ? y1_reg : $signed({4'd0, h_eff});

    logic [12:0] xs_reg, xe_reg, ye_reg, x_reg, y_reg;
    logic [CW-1:0] row_base_reg;
    logic        empty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.clamp)
        begin
            nonempty_reg <= 1'b0;
        end
        if (cmd.clip)
        begin
            // Original clamped box must be non-empty, then clipped one too
            empty_reg    <= !((y0_reg < y1_reg) && (x0_reg < x1_reg)
                              && (cx0 < cx1) && (cy0 < cy1));
            xs_reg       <= cx0[12:0];
            xe_reg       <= cx1[12:0];
            ye_reg       <= cy1[12:0];
            x_reg        <= cx0[12:0];
            y_reg        <= cy0[12:0];
            row_base_reg <= CW'(w_eff * cy0[12:0]);
        end
        else if (cmd.write)
        begin
            if (x_reg + 13'd1 == xe_reg)
            begin
                x_reg        <= xs_reg;
                y_reg        <= y_reg + 13'd1;
                row_base_reg <= row_base_reg + CW'(w_eff);
            end
            else
            begin
                x_reg <= x_reg + 13'd1;
            end
        end
    end

    logic [CW-1:0] cell_addr;
    assign cell_addr = row_base_reg + CW'(x_reg);

    // Clearing pass over cell heads, occupancy and owner counts after reset
    logic [CW:0] clr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Pool state
    logic [23:0]   free_head_reg;
    logic [UW-1:0] pool_used_reg;
    logic [12:0]   live_count_reg;
    logic          from_free_reg;
    logic [RW-1:0] rec_reg;
    logic          free_ok;
    logic [16:0]   cells_added_reg;
    logic          pool_full_reg;

    assign free_ok = (free_head_reg != gbcr_pkg::INDEX_NONE)
                   && (free_head_reg < 24'(gbcr_pkg::RECORD_POOL_DEPTH));

    // Memories
    logic [31:0] heads_mem [gbcr_pkg::CELL_COUNT];
    logic [31:0] occ_mem   [gbcr_pkg::OCC_WORDS];
    logic [31:0] links_mem [gbcr_pkg::RECORD_POOL_DEPTH];
    logic [7:0]  owner_mem [gbcr_pkg::RECORD_POOL_DEPTH];
    logic [12:0] count_mem [gbcr_pkg::OWNER_SLOTS];
    logic [31:0] head_rd, occ_rd, link_rd;
    logic [12:0] count_rd;
    logic [gbcr_pkg::OWN_W-1:0] own_slot;

    assign own_slot = gbcr_pkg::OWN_W'(item_reg.owner_id);

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            heads_mem[clr_reg[CW-1:0]] <= {8'd0, gbcr_pkg::INDEX_NONE};
            occ_mem[clr_reg[gbcr_pkg::OCC_W-1:0]] <= '0;
            count_mem[clr_reg[gbcr_pkg::OWN_W-1:0]] <= '0;
        end
        if (cmd.read)
        begin
            head_rd  <= heads_mem[cell_addr];
            occ_rd   <= occ_mem[cell_addr[CW-1:5]];
            link_rd  <= links_mem[free_head_reg[RW-1:0]];
            count_rd <= count_mem[own_slot];
        end
        if (cmd.write)
        begin
            heads_mem[cell_addr] <= {head_rd[31:24], 24'(rec_reg)};
            if (item_reg.layer_flag == 8'd0)
            begin
                occ_mem[cell_addr[CW-1:5]] <= occ_rd | (32'd1 << cell_addr[4:0]);
            end
            links_mem[rec_reg] <= {item_reg.layer_flag, head_rd[23:0]};
            owner_mem[rec_reg] <= item_reg.owner_id;
            count_mem[own_slot] <= count_rd + 13'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            from_free_reg <= free_ok;
            rec_reg       <= free_ok ? free_head_reg[RW-1:0] : pool_used_reg[RW-1:0];
        end
    end

    // Pool counters and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg   <= gbcr_pkg::INDEX_NONE;
            pool_used_reg   <= '0;
            live_count_reg  <= '0;
            cells_added_reg <= '0;
            pool_full_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clip)
            begin
                cells_added_reg <= '0;
                pool_full_reg   <= 1'b0;
            end
            if (cmd.full)
            begin
                pool_full_reg <= 1'b1;
            end
            if (cmd.write)
            begin
                if (from_free_reg) free_head_reg <= link_rd[23:0];
                else               pool_used_reg <= pool_used_reg + 1'b1;
                live_count_reg  <= live_count_reg + 13'd1;
                cells_added_reg <= cells_added_reg + 17'd1;
            end
        end
    end

    assign cells_added = cells_added_reg;
    assign pool_full   = pool_full_reg;

    assign status.clear_last = (clr_reg == (CW + 1)'(gbcr_pkg::CELL_COUNT - 1));
    assign status.empty      = empty_reg || nonempty_reg;
    assign status.pool_ok    = free_ok
                             || (pool_used_reg < UW'(gbcr_pkg::RECORD_POOL_DEPTH));
    assign status.walk_last  = (x_reg + 13'd1 == xe_reg) && (y_reg + 13'd1 == ye_reg);

    // Owner ids are kept for the collection side; live count is status only
    logic unused_ok;
    assign unused_ok = ^{owner_mem[0], live_count_reg};
endmodule

/* design/grid_box_cell_registration.sv */
// Top level of the grid box cell registration block.
// Depends on gbcr_pkg, gbcr_if, gbcr_ctrl and gbcr_datapath.
//
// Usage:
//  - box_in carries one box item (box corners, owner_id, layer_flag).
//  - result_out returns one item per box: cells_added and pool_full.
//  - cfg_we/cfg_index/cfg_data write the six grid and extent registers.
//    The user writes them only while the block is idle; nothing enforces it.
//  - Each box is clamped to the extent, clipped to the grid, then its cells
//    are walked row by row. Each cell has a memory read, a wait for the
//    read data and a write back.
//  - An empty box skips the walk; when the pool runs out the walk ends and
//    pool_full is set. A new box is taken only after the previous result
//    has been loaded into the output register.
//  - After reset a clearing pass writes every cell head, one per cycle;
//    no box is accepted during the pass.
//  - The result sits in an output register; while the receiver stalls the
//    next box is still taken and walked, and its result waits until the
//    held one leaves. No further box is taken meanwhile.
module grid_box_cell_registration (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gbcr_pkg::IDX_W-1:0]  cfg_index,
    input  logic [gbcr_pkg::CFG_W-1:0]  cfg_data,
    gbcr_box_if.sink                    box_in,
    gbcr_result_if.source               result_out
);
    gbcr_pkg::cmd_t    cmd;
    gbcr_pkg::status_t status;
    logic              out_load;
    logic [16:0]       cells_added;
    logic              pool_full;
    logic              out_valid_reg;
    logic              out_busy;

    // Output register cannot take a new result this cycle
    assign out_busy = out_valid_reg && !result_out.ready;

    gbcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (box_in.valid),
        .in_ready (box_in.ready),
        .out_load (out_load),
        .out_busy (out_busy),
        .status   (status),
        .cmd      (cmd)
    );

    gbcr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (box_in.data),
        .cmd         (cmd),
        .status      (status),
        .cells_added (cells_added),
        .pool_full   (pool_full)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_out.data.cells_added <= cells_added;
            result_out.data.pool_full   <= pool_full;
        end
    end

    assign result_out.valid = out_valid_reg;
endmodule
